>>> rtl/grc_pkg.sv
// Shared types, codes and constants of the glyph column rasteriser.
package grc_pkg;

  localparam int unsigned STORE_DEPTH      = 32768;
  localparam int unsigned UPPER_SET_BASE   = 16384;
  localparam int unsigned MAX_GLYPH_WIDTH  = 16;
  localparam int unsigned MAX_GLYPH_HEIGHT = 24;
  localparam int unsigned MAX_RESULTS      = 64;

  localparam int unsigned CFG_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [7:0]  CODE_FIRST = 8'h20;
  localparam logic [7:0]  CODE_UPPER = 8'hC0;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_CURSOR = 2'd1,
    OP_DRAW   = 2'd2,
    OP_NONE   = 2'd3
  } grc_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER_WIDTH  = 2'd0,
    CFG_LOWER_HEIGHT = 2'd1,
    CFG_UPPER_WIDTH  = 2'd2,
    CFG_UPPER_HEIGHT = 2'd3
  } grc_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MULT,
    ST_RD_WIDTH,
    ST_WIDTH,
    ST_EMIT
  } grc_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [14:0] store_addr;
    logic [7:0]  store_data;
    logic [7:0]  char_code;
    logic [7:0]  gap;
    logic        transparent;
    logic [15:0] new_x;
    logic [15:0] new_y;
  } grc_req_t;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  ink_bits;
    logic [7:0]  write_bits;
    logic        last;
  } grc_res_t;

  typedef struct packed {
    logic idle;
    logic setup;
    logic mult;
    logic rd_width;
    logic take_width;
    logic emit;
    logic advance;
  } grc_cmd_t;

  typedef struct packed {
    logic draw_start;
    logic skip;
    logic gw_zero;
    logic slot_free;
    logic last_seg;
  } grc_sts_t;

endpackage

>>> rtl/grc_if.sv
// Request and result channel interfaces of the glyph column rasteriser.
interface grc_req_if;
  logic               valid;
  logic               ready;
  grc_pkg::grc_req_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface grc_res_if;
  logic               valid;
  logic               ready;
  grc_pkg::grc_res_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/grc_ctrl.sv
// Sequencing state machine of the glyph column rasteriser.
module grc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grc_pkg::grc_sts_t  sts_i,
  output grc_pkg::grc_cmd_t  cmd_o
);

  grc_pkg::grc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      grc_pkg::ST_IDLE: begin
        if (sts_i.draw_start) state_d = grc_pkg::ST_SETUP;
      end
      grc_pkg::ST_SETUP: begin
        state_d = sts_i.skip ? grc_pkg::ST_IDLE : grc_pkg::ST_MULT;
      end
      grc_pkg::ST_MULT: begin
        state_d = grc_pkg::ST_RD_WIDTH;
      end
      grc_pkg::ST_RD_WIDTH: begin
        state_d = grc_pkg::ST_WIDTH;
      end
      grc_pkg::ST_WIDTH: begin
        state_d = sts_i.gw_zero ? grc_pkg::ST_IDLE : grc_pkg::ST_EMIT;
      end
      grc_pkg::ST_EMIT: begin
        if (sts_i.slot_free && sts_i.last_seg) state_d = grc_pkg::ST_IDLE;
      end
      default: begin
        state_d = grc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      grc_pkg::ST_IDLE: begin
        cmd_o.idle = 1'b1;
      end
      grc_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      grc_pkg::ST_MULT: begin
        cmd_o.mult = 1'b1;
      end
      grc_pkg::ST_RD_WIDTH: begin
        cmd_o.rd_width = 1'b1;
      end
      grc_pkg::ST_WIDTH: begin
        cmd_o.take_width = 1'b1;
        cmd_o.advance    = sts_i.gw_zero;
      end
      grc_pkg::ST_EMIT: begin
        cmd_o.emit    = sts_i.slot_free;
        cmd_o.advance = sts_i.slot_free && sts_i.last_seg;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> rtl/grc_datapath.sv
// Font store, cursor, set registers, address arithmetic and result register.
module grc_datapath #(
  parameter int unsigned StoreDepth     = grc_pkg::STORE_DEPTH,
  parameter int unsigned UpperSetBase   = grc_pkg::UPPER_SET_BASE,
  parameter int unsigned MaxGlyphWidth  = grc_pkg::MAX_GLYPH_WIDTH,
  parameter int unsigned MaxGlyphHeight = grc_pkg::MAX_GLYPH_HEIGHT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [grc_pkg::CFG_W-1:0]    cfg_data_i,
  grc_req_if.sink                      req,
  grc_res_if.source                    res,
  input  grc_pkg::grc_cmd_t            cmd_i,
  output grc_pkg::grc_sts_t            sts_o
);

  localparam int unsigned AddrW    = $clog2(StoreDepth);
  localparam int unsigned GwW      = $clog2(MaxGlyphWidth + 1);
  localparam int unsigned ColW     = (MaxGlyphWidth > 1) ? $clog2(MaxGlyphWidth) : 1;
  localparam int unsigned MaxBytes = MaxGlyphHeight / 8 + 1;
  localparam int unsigned BytesW   = $clog2(MaxBytes + 1);
  localparam int unsigned BIdxW    = $clog2(MaxBytes);
  localparam int unsigned StrideW  = $clog2(MaxGlyphWidth * MaxBytes + 2);
  localparam int unsigned ProdW    = 8 + StrideW;
  localparam int unsigned CntW     = $clog2(grc_pkg::MAX_RESULTS);
  localparam logic [AddrW-1:0] BaseAddr = AddrW'(UpperSetBase % StoreDepth);

  logic [7:0] mem [StoreDepth];
  logic [7:0] rd_q;

  logic [grc_pkg::CFG_W-1:0] lw_q, lh_q, uw_q, uh_q;
  logic [15:0] cursor_x_q, cursor_y_q;
  logic [7:0]  code_q, gap_q;
  logic        transp_q;

  logic               upper_q;
  logic [GwW-1:0]     sw_q, gw_q;
  logic [BytesW-1:0]  bytes_q;
  logic [7:0]         rel_q;
  logic [StrideW-1:0] stride_q;
  logic [AddrW-1:0]   rec_q, ptr_q;
  logic [ColW-1:0]    col_q;
  logic [BIdxW-1:0]   byte_q;
  logic [CntW-1:0]    cnt_q;

  grc_pkg::grc_res_t out_q;
  logic              out_valid_q;

  logic accept;
  logic upper;
  logic [grc_pkg::CFG_W-1:0] sel_w, sel_h, lim_h;
  logic [GwW-1:0]     lim_w, gw_d, adv_w;
  logic [BytesW-1:0]  bytes_d;
  logic [7:0]         rel_d;
  logic [StrideW-1:0] stride_d;
  logic [ProdW-1:0]   prod;
  logic [AddrW-1:0]   rec_d, rd_addr, wr_addr;
  logic [16:0]        wr_addr_full;
  logic               rd_en, col_last, byte_last, last_seg, slot_free;

  assign accept    = req.valid && cmd_i.idle;
  assign req.ready = cmd_i.idle;

  // Set selection and record geometry.
  assign upper  = (code_q >= grc_pkg::CODE_UPPER);
  assign sel_w  = upper ? uw_q : lw_q;
  assign sel_h  = upper ? uh_q : lh_q;
  assign lim_w  = ({1'b0, sel_w} > 6'(MaxGlyphWidth)) ? GwW'(MaxGlyphWidth) : GwW'(sel_w);
  assign lim_h  = ({1'b0, sel_h} > 6'(MaxGlyphHeight)) ? 5'(MaxGlyphHeight) : sel_h;
  assign bytes_d  = BytesW'(lim_h[4:3]) + BytesW'(1);
  assign rel_d    = upper ? (code_q - grc_pkg::CODE_UPPER) : (code_q - grc_pkg::CODE_FIRST);
  assign stride_d = StrideW'(lim_w) * StrideW'(bytes_d) + StrideW'(1);

  assign prod  = ProdW'(rel_q) * ProdW'(stride_q);
  assign rec_d = AddrW'(prod) + (upper_q ? BaseAddr : AddrW'(0));

  assign gw_d  = (rd_q > 8'(sw_q)) ? sw_q : GwW'(rd_q);
  assign adv_w = cmd_i.take_width ? GwW'(0) : gw_q;

  assign col_last  = (GwW'(col_q) + GwW'(1)) == gw_q;
  assign byte_last = (BytesW'(byte_q) + BytesW'(1)) == bytes_q;
  assign last_seg  = (col_last && byte_last) || (cnt_q == CntW'(grc_pkg::MAX_RESULTS - 1));
  assign slot_free = !out_valid_q || res.ready;

  assign rd_en   = cmd_i.rd_width || cmd_i.take_width || cmd_i.emit;
  assign rd_addr = cmd_i.rd_width ? rec_q :
                   (cmd_i.take_width ? rec_q + AddrW'(1) : ptr_q + AddrW'(1));
  assign wr_addr_full = {2'b00, req.data.store_addr};
  assign wr_addr      = wr_addr_full[AddrW-1:0];

  assign sts_o.draw_start = accept && (req.data.opcode == grc_pkg::OP_DRAW);
  assign sts_o.skip       = (code_q < grc_pkg::CODE_FIRST) || (sel_w == '0);
  assign sts_o.gw_zero    = (rd_q == 8'd0);
  assign sts_o.slot_free  = slot_free;
  assign sts_o.last_seg   = last_seg;

  assign res.valid = out_valid_q;
  assign res.data  = out_q;

  always_ff @(posedge clk_i) begin
    if (accept && (req.data.opcode == grc_pkg::OP_WRITE)) begin
      mem[wr_addr] <= req.data.store_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= '0;
      lh_q <= grc_pkg::CFG_W'(8);
      uw_q <= '0;
      uh_q <= grc_pkg::CFG_W'(8);
    end else if (cfg_we_i) begin
      case (grc_pkg::grc_cfg_idx_e'(cfg_idx_i))
        grc_pkg::CFG_LOWER_WIDTH:  lw_q <= cfg_data_i;
        grc_pkg::CFG_LOWER_HEIGHT: lh_q <= cfg_data_i;
        grc_pkg::CFG_UPPER_WIDTH:  uw_q <= cfg_data_i;
        grc_pkg::CFG_UPPER_HEIGHT: uh_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else if (accept && (req.data.opcode == grc_pkg::OP_CURSOR)) begin
      cursor_x_q <= req.data.new_x;
      cursor_y_q <= req.data.new_y;
    end else if (cmd_i.advance) begin
      cursor_x_q <= cursor_x_q + 16'(adv_w) + 16'(gap_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sts_o.draw_start) begin
      code_q   <= req.data.char_code;
      gap_q    <= req.data.gap;
      transp_q <= req.data.transparent;
    end
    if (cmd_i.setup) begin
      upper_q  <= upper;
      sw_q     <= lim_w;
      bytes_q  <= bytes_d;
      rel_q    <= rel_d;
      stride_q <= stride_d;
    end
    if (cmd_i.mult) begin
      rec_q <= rec_d;
    end
    if (cmd_i.take_width) begin
      gw_q   <= gw_d;
      ptr_q  <= rd_addr;
      col_q  <= '0;
      byte_q <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.emit) begin
      out_q.pixel_x    <= cursor_x_q + 16'(col_q);
      out_q.pixel_y    <= cursor_y_q + 16'({byte_q, 3'b000});
      out_q.ink_bits   <= rd_q;
      out_q.write_bits <= transp_q ? rd_q : 8'hFF;
      out_q.last       <= last_seg;
      ptr_q <= rd_addr;
      cnt_q <= cnt_q + CntW'(1);
      if (byte_last) begin
        byte_q <= '0;
        col_q  <= col_q + ColW'(1);
      end else begin
        byte_q <= byte_q + BIdxW'(1);
      end
    end
  end

endmodule

>>> rtl/glyph_column_rasterizer_unit.sv
// Top level of the glyph column rasteriser: controller and datapath.
//
//   channel   direction  handshake        payload
//   req_i     in         valid / ready    grc_req_t (opcode, store, draw, cursor fields)
//   res_o     out        valid / ready    grc_res_t (pixel_x, pixel_y, ink, write, last)
//   cfg       in         cfg_we_i         cfg_idx_i, cfg_data_i
//
// Store writes and cursor loads are taken one request per cycle.
// A draw steps through set-up (set select, record multiply, width read), then emits
// one column byte per cycle unless res_o stalls, as the font store has one read port.
// Ignored codes and absent sets end at set-up; a zero-width glyph at its width read.
// Back-pressure on res_o holds the column sequencer; requests wait until it is idle.
// Reset clears the controller state, result valid flag, cursor and set widths, and
// loads 8 into the set heights; the font store is undefined until written.
module glyph_column_rasterizer_unit #(
  parameter int unsigned StoreDepth     = grc_pkg::STORE_DEPTH,
  parameter int unsigned UpperSetBase   = grc_pkg::UPPER_SET_BASE,
  parameter int unsigned MaxGlyphWidth  = grc_pkg::MAX_GLYPH_WIDTH,
  parameter int unsigned MaxGlyphHeight = grc_pkg::MAX_GLYPH_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [grc_pkg::CFG_W-1:0]     cfg_data_i,
  grc_req_if.sink                       req_i,
  grc_res_if.source                     res_o
);

  grc_pkg::grc_cmd_t cmd;
  grc_pkg::grc_sts_t sts;

  grc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  grc_datapath #(
    .StoreDepth     (StoreDepth),
    .UpperSetBase   (UpperSetBase),
    .MaxGlyphWidth  (MaxGlyphWidth),
    .MaxGlyphHeight (MaxGlyphHeight)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_i),
    .res        (res_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

>>> rtl/grc_checker.sv
// Port-level assertions of the glyph column rasteriser and their bind.
module grc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input grc_pkg::grc_res_t res_data_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result changed while stalled");

  a_write_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_data_i.write_bits == 8'hFF) ||
                    (res_data_i.write_bits == res_data_i.ink_bits))
    else $error("write mask is neither opaque nor the ink mask");

  a_busy_mid_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_data_i.last |-> !req_ready_i)
    else $error("request taken while a glyph is still being drawn");

  a_glyph_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_data_i.last |=> res_valid_i &&
      ((res_data_i.pixel_x == $past(res_data_i.pixel_x)) ||
       (res_data_i.pixel_x == $past(res_data_i.pixel_x) + 16'd1)))
    else $error("glyph segment did not follow its predecessor");

endmodule

bind glyph_column_rasterizer_unit grc_checker u_grc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
